// File: rtl/core/tce_pkg.sv
// ============================================================================
// tce_pkg - Taylor cosine evaluator shared definitions
// Widths, fixed-point constants, reciprocal table, item types and the
// sequencer state type.
// ============================================================================
package tce_pkg;

   localparam int MAX_TERMS = 10;
   localparam int FRAC_BITS = 16;

   localparam int ANGLE_W = 20;
   localparam int COUNT_W = 4;
   localparam int SUM_W   = 28;
   localparam int X2_W    = 2 * (ANGLE_W - 1) - FRAC_BITS + 1;
   localparam int TERM_W  = 34;
   localparam int P_W     = TERM_W + X2_W - 1 - FRAC_BITS + 1;
   localparam int RECIP_W = 32;
   localparam int P_HI_W  = P_W - RECIP_W;
   localparam int MUL_A_W = TERM_W;
   localparam int MUL_B_W = RECIP_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SUMT_W  = P_HI_W + RECIP_W + 1;
   localparam int ACC_W   = 40;

   localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << FRAC_BITS;
   localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (TERM_W - 1);

   localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'((2 ** (SUM_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-(2 ** (SUM_W - 1)));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LOAD,
      ST_MUL_X,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic [COUNT_W-1:0]        term_count;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] cosine_sum;
      logic                    saturated;
   } rsp_type;

   // 1/((2k-1)*2k) in unsigned Q0.32, rounded to nearest
   function automatic logic [RECIP_W-1:0] recip_q32(input logic [COUNT_W-1:0] k);
      logic [RECIP_W-1:0] r;
      unique case (k)
         4'd1:    r = 32'd2147483648;
         4'd2:    r = 32'd357913941;
         4'd3:    r = 32'd143165577;
         4'd4:    r = 32'd76695845;
         4'd5:    r = 32'd47721859;
         4'd6:    r = 32'd32537631;
         4'd7:    r = 32'd23598721;
         4'd8:    r = 32'd17895697;
         4'd9:    r = 32'd14035841;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/tce_mul.sv
// ============================================================================
// tce_mul - shared unsigned multiplier
// One registered 34 x 32 bit product, reused by the sequencer for the angle
// square, the term by x squared product and both reciprocal partial products.
// ============================================================================
module tce_mul (
   input  logic                           clock,
   input  logic [tce_pkg::MUL_A_W-1:0]    mul_a,
   input  logic [tce_pkg::MUL_B_W-1:0]    mul_b,
   output logic [tce_pkg::PROD_W-1:0]     prod
);

   logic [tce_pkg::PROD_W-1:0] prod_ff;
   logic [tce_pkg::PROD_W-1:0] prod_in;

   assign prod_in = tce_pkg::PROD_W'(mul_a) * tce_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: rtl/core/taylor_cosine_evaluator.sv
// ============================================================================
// taylor_cosine_evaluator - fixed-point Taylor series cosine
// Sums the first term_count terms (clipped to MAX_TERMS) of the cosine series
// for a Q4.16 angle, building each term from the last through one shared
// multiplier, and returns the Q12.16 sum with saturation flag.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------
//   request   start, busy, req_data          taken when start && !busy
//   response  rsp_strobe, rsp_data           one-cycle strobe, no back-pressure
//
// A count of n >= 2 keeps busy high through the square and load states, the
// MUL_X, MUL_LO, MUL_HI and ACCUM states for each term after the first, and
// the saturation state. A count of 0 or 1 goes straight to saturation.
// The item appears on the response ports in the first cycle with busy low,
// while the next item may already be taken. The shared multiplier sets the rate.
// Reset clears the sequencer and the strobe, leaving the block idle for start.
// ============================================================================
module taylor_cosine_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tce_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tce_pkg::rsp_type rsp_data
);

   tce_pkg::state_type state_ff, state_in;

   logic [tce_pkg::COUNT_W-1:0]      k_ff, k_in;
   logic [tce_pkg::COUNT_W-1:0]      last_ff, last_in;
   logic [tce_pkg::ANGLE_W-1:0]      mag_ff, mag_in;
   logic [tce_pkg::X2_W-1:0]         x2_ff, x2_in;
   logic [tce_pkg::TERM_W-1:0]       term_ff, term_in;
   logic [tce_pkg::P_HI_W-1:0]       p_hi_ff, p_hi_in;
   logic [tce_pkg::RECIP_W-1:0]      carry_ff, carry_in;
   logic signed [tce_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                             clamp_ff, clamp_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   tce_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic [tce_pkg::MUL_A_W-1:0]      mul_a;
   logic [tce_pkg::MUL_B_W-1:0]      mul_b;
   logic [tce_pkg::PROD_W-1:0]       prod;

   logic [tce_pkg::COUNT_W-1:0]      count_clip;
   logic [tce_pkg::SUMT_W-1:0]       term_sum;
   logic signed [tce_pkg::ACC_W-1:0] term_ext;

   assign count_clip = (req_data.term_count > tce_pkg::COUNT_W'(tce_pkg::MAX_TERMS))
                       ? tce_pkg::COUNT_W'(tce_pkg::MAX_TERMS) : req_data.term_count;

   assign busy = (state_ff != tce_pkg::ST_IDLE);

   tce_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tce_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (count_clip <= tce_pkg::COUNT_W'(1)) ? tce_pkg::ST_FINISH
                                                               : tce_pkg::ST_SQUARE;
            end
         end
         tce_pkg::ST_SQUARE: state_in = tce_pkg::ST_LOAD;
         tce_pkg::ST_LOAD:   state_in = tce_pkg::ST_MUL_X;
         tce_pkg::ST_MUL_X:  state_in = tce_pkg::ST_MUL_LO;
         tce_pkg::ST_MUL_LO: state_in = tce_pkg::ST_MUL_HI;
         tce_pkg::ST_MUL_HI: state_in = tce_pkg::ST_ACCUM;
         tce_pkg::ST_ACCUM: begin
            state_in = (k_ff == last_ff) ? tce_pkg::ST_FINISH : tce_pkg::ST_MUL_X;
         end
         tce_pkg::ST_FINISH: state_in = tce_pkg::ST_IDLE;
         default:            state_in = tce_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      k_in          = k_ff;
      last_in       = last_ff;
      mag_in        = mag_ff;
      x2_in         = x2_ff;
      term_in       = term_ff;
      p_hi_in       = p_hi_ff;
      carry_in      = carry_ff;
      acc_in        = acc_ff;
      clamp_in      = clamp_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mul_a         = '0;
      mul_b         = '0;
      term_sum      = '0;
      term_ext      = '0;
      unique case (state_ff)
         tce_pkg::ST_IDLE: begin
            if (start) begin
               mag_in   = req_data.angle[tce_pkg::ANGLE_W-1]
                          ? (~req_data.angle + tce_pkg::ANGLE_W'(1)) : req_data.angle;
               last_in  = count_clip - tce_pkg::COUNT_W'(1);
               k_in     = tce_pkg::COUNT_W'(1);
               term_in  = tce_pkg::TERM_ONE;
               clamp_in = 1'b0;
               acc_in   = (count_clip == '0) ? '0 : tce_pkg::ACC_W'(tce_pkg::TERM_ONE);
            end
         end
         tce_pkg::ST_SQUARE: begin
            mul_a = tce_pkg::MUL_A_W'(mag_ff);
            mul_b = tce_pkg::MUL_B_W'(mag_ff);
         end
         tce_pkg::ST_LOAD: begin
            x2_in = prod[tce_pkg::FRAC_BITS +: tce_pkg::X2_W];
         end
         tce_pkg::ST_MUL_X: begin
            mul_a = term_ff;
            mul_b = tce_pkg::MUL_B_W'(x2_ff);
         end
         tce_pkg::ST_MUL_LO: begin
            p_hi_in = prod[tce_pkg::FRAC_BITS + tce_pkg::RECIP_W +: tce_pkg::P_HI_W];
            mul_a   = tce_pkg::MUL_A_W'(prod[tce_pkg::FRAC_BITS +: tce_pkg::RECIP_W]);
            mul_b   = tce_pkg::recip_q32(k_ff);
         end
         tce_pkg::ST_MUL_HI: begin
            carry_in = prod[tce_pkg::RECIP_W +: tce_pkg::RECIP_W];
            mul_a    = tce_pkg::MUL_A_W'(p_hi_ff);
            mul_b    = tce_pkg::recip_q32(k_ff);
         end
         tce_pkg::ST_ACCUM: begin
            term_sum = tce_pkg::SUMT_W'(prod[tce_pkg::SUMT_W-2:0])
                       + tce_pkg::SUMT_W'(carry_ff);
            if (term_sum > tce_pkg::SUMT_W'(tce_pkg::TERM_CAP)) begin
               term_in  = tce_pkg::TERM_CAP;
               clamp_in = 1'b1;
            end else begin
               term_in  = term_sum[tce_pkg::TERM_W-1:0];
            end
            term_ext = tce_pkg::ACC_W'(term_in);
            acc_in   = k_ff[0] ? (acc_ff - term_ext) : (acc_ff + term_ext);
            k_in     = k_ff + tce_pkg::COUNT_W'(1);
         end
         tce_pkg::ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            priority if (clamp_ff) begin
               rsp_data_in.cosine_sum = acc_ff[tce_pkg::ACC_W-1]
                                        ? tce_pkg::SUM_MIN[tce_pkg::SUM_W-1:0]
                                        : tce_pkg::SUM_MAX[tce_pkg::SUM_W-1:0];
               rsp_data_in.saturated  = 1'b1;
            end else if (acc_ff > tce_pkg::SUM_MAX) begin
               rsp_data_in.cosine_sum = tce_pkg::SUM_MAX[tce_pkg::SUM_W-1:0];
               rsp_data_in.saturated  = 1'b1;
            end else if (acc_ff < tce_pkg::SUM_MIN) begin
               rsp_data_in.cosine_sum = tce_pkg::SUM_MIN[tce_pkg::SUM_W-1:0];
               rsp_data_in.saturated  = 1'b1;
            end else begin
               rsp_data_in.cosine_sum = acc_ff[tce_pkg::SUM_W-1:0];
               rsp_data_in.saturated  = 1'b0;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tce_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      last_ff     <= last_in;
      mag_ff      <= mag_in;
      x2_ff       <= x2_in;
      term_ff     <= term_in;
      p_hi_ff     <= p_hi_in;
      carry_ff    <= carry_in;
      acc_ff      <= acc_in;
      clamp_ff    <= clamp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == tce_pkg::ST_FINISH) && !busy)
      else $error("response strobe without a finishing cycle");

   a_clamp_saturates: assert property (@(posedge clock) disable iff (reset)
      state_ff == tce_pkg::ST_FINISH && clamp_ff |=> rsp_strobe && rsp_data.saturated)
      else $error("clamped term did not force saturation");

   a_term_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == tce_pkg::ST_MUL_X |-> k_ff != '0 && k_ff <= last_ff)
      else $error("term index out of range");

endmodule

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top - Taylor cosine evaluator testbench
// Drives angle/term-count items through the start/busy handshake with random
// idle gaps, predicts each fixed-point partial cosine sum and its saturation
// flag, and checks every strobed result against the oldest prediction.
// ============================================================================
module tb_top;
   import tce_pkg::*;

   class cosine_board;
      rsp_type     sums_due[$];
      int unsigned mismatches;
      int unsigned items_taken;
      int unsigned results_seen;
      int unsigned clipped_seen;
      logic [15:0] counts_seen;

      function new();
         mismatches   = 0;
         items_taken  = 0;
         results_seen = 0;
         clipped_seen = 0;
         counts_seen  = '0;
      endfunction

      // 1/((2k-1)*2k) in unsigned Q0.32
      function logic [31:0] inverse_pair(int k);
         case (k)
            1: return 32'd2147483648;
            2: return 32'd357913941;
            3: return 32'd143165577;
            4: return 32'd76695845;
            5: return 32'd47721859;
            6: return 32'd32537631;
            7: return 32'd23598721;
            8: return 32'd17895697;
            9: return 32'd14035841;
            default: return 32'd0;
         endcase
      endfunction

      function rsp_type series_sum(req_type item);
         longint            ang;
         logic [63:0]       mag;
         logic [63:0]       x_sq;
         logic [63:0]       term;
         logic [63:0]       prod;
         logic [95:0]       scaled;
         longint            acc;
         int                n;
         bit                huge;
         rsp_type           res;
         longint            sum_top;
         longint            sum_bottom;
         sum_top    = (longint'(1) <<< (SUM_W - 1)) - 1;
         sum_bottom = -(longint'(1) <<< (SUM_W - 1));
         res  = '0;
         huge = 1'b0;
         n    = item.term_count;
         if (n == 0) return res;
         if (n > MAX_TERMS) n = MAX_TERMS;
         ang  = item.angle;
         mag  = (ang < 0) ? 64'(-ang) : 64'(ang);
         x_sq = (mag * mag) >> FRAC_BITS;
         term = 64'd1 << FRAC_BITS;
         acc  = longint'(term);
         for (int k = 1; k < n; k++) begin
            prod   = (term * x_sq) >> FRAC_BITS;
            scaled = {32'd0, prod} * {64'd0, inverse_pair(k)};
            term   = scaled[95:32];
            if (term > (64'd1 << (TERM_W - 1))) begin
               term = 64'd1 << (TERM_W - 1);
               huge = 1'b1;
            end
            if (k % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
         end
         if (huge) begin
            acc = (acc >= 0) ? sum_top : sum_bottom;
            res.saturated = 1'b1;
         end else if (acc > sum_top) begin
            acc = sum_top;
            res.saturated = 1'b1;
         end else if (acc < sum_bottom) begin
            acc = sum_bottom;
            res.saturated = 1'b1;
         end
         res.cosine_sum = acc[SUM_W-1:0];
         return res;
      endfunction

      function void note_item(req_type item);
         sums_due.push_back(series_sum(item));
         items_taken++;
         counts_seen[item.term_count] = 1'b1;
      endfunction

      function void check_sum(rsp_type got);
         rsp_type want;
         results_seen++;
         if (got.saturated) clipped_seen++;
         if (sums_due.size() == 0) begin
            $error("result with no item outstanding: cosine_sum %0d saturated %0d",
                   got.cosine_sum, got.saturated);
            mismatches++;
            return;
         end
         want = sums_due.pop_front();
         if (got.cosine_sum !== want.cosine_sum) begin
            $error("cosine_sum: expected %0d, got %0d", want.cosine_sum, got.cosine_sum);
            mismatches++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return sums_due.size();
      endfunction
   endclass

   localparam int RANDOM_ITEMS = 450;
   localparam int DIRECTED_N   = 23;
   localparam int DIR_ANGLE [DIRECTED_N] = '{
      0, 0, 0, 524287, -524288, -524288, 524287, -1, 1, 205887, -205887, 102944,
      65536, -65536, 524287, -524288, 524287, -524288, 131072, -131072, 524287,
      300000, 411775};
   localparam int DIR_COUNT [DIRECTED_N] = '{
      0, 1, 10, 10, 10, 15, 11, 10, 2, 10, 10, 10, 5, 9, 0, 1, 4, 7, 3, 6, 12, 8, 13};

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   cosine_board board = new();

   taylor_cosine_evaluator i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && start && !busy) board.note_item(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_sum(rsp_data);
   end

   function automatic int pick_gap(bit burst);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (burst || sel < 50) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type pick_item();
      req_type     item;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)      item.angle = ANGLE_W'($urandom);
      else if (sel < 85) item.angle = ANGLE_W'($urandom_range(0, 823550) - 411775);
      else               item.angle = ANGLE_W'($urandom_range(0, 8191) - 4096);
      sel = $urandom_range(0, 99);
      if (sel < 8)       item.term_count = '0;
      else if (sel < 15) item.term_count = COUNT_W'($urandom_range(MAX_TERMS + 1, 15));
      else               item.term_count = COUNT_W'($urandom_range(1, MAX_TERMS));
      return item;
   endfunction

   // hold start and the item until the block takes it
   task automatic issue(input req_type item, input int idle_cycles);
      if (idle_cycles > 0) begin
         start <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      req_type item;
      bit      burst;
      burst = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_N; i++) begin
         item.angle      = ANGLE_W'(DIR_ANGLE[i]);
         item.term_count = COUNT_W'(DIR_COUNT[i]);
         issue(item, pick_gap(1'b0));
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         issue(pick_item(), pick_gap(burst));
      end
      start <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d items taken, %0d results checked, %0d clipped sums",
               board.items_taken, board.results_seen, board.clipped_seen);
      $display("term counts exercised (bit per count): %b", board.counts_seen);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
